// File: design/aavr_pkg.sv
// ----------------------------------------------------------------------------
// aavr_pkg
// Shared constants, CORDIC arctangent table and fixed-point helpers for the
// axis-angle vector rotation core.
// ----------------------------------------------------------------------------
`default_nettype none

package aavr_pkg;

    localparam int FRAC_BITS    = 30;
    localparam int SQRT_STEPS   = 32;   // one root bit per stage, 64-bit radicand
    localparam int DIV_QBITS    = 31;   // unit component magnitude is at most 2^30
    localparam int CORDIC_ITERS = 30;

    localparam int SQRT_LAT   = SQRT_STEPS;
    localparam int DIV_LAT    = DIV_QBITS + 2;
    localparam int CORDIC_LAT = CORDIC_ITERS + 2;
    localparam int ROT_LAT    = 7;

    localparam logic signed [33:0] HALF_PI_Q30     = 34'sd1686629713;
    localparam logic signed [33:0] PI_Q30          = 34'sd3373259426;
    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    localparam logic signed [31:0] ONE_Q30   = 32'sd1073741824;
    localparam logic signed [31:0] M_ONE_Q30 = -32'sd1073741824;

    typedef logic signed [31:0] t_q30;
    typedef logic signed [35:0] t_mraw;

    function automatic logic [31:0] atan_lut(input logic [4:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:    v = 32'h3243F6A8;
            5'd1:    v = 32'h1DAC6705;
            5'd2:    v = 32'h0FADBAFC;
            5'd3:    v = 32'h07F56EA6;
            5'd4:    v = 32'h03FEAB76;
            5'd5:    v = 32'h01FFD55B;
            5'd6:    v = 32'h00FFFAAA;
            5'd7:    v = 32'h007FFF55;
            5'd8:    v = 32'h003FFFEA;
            5'd9:    v = 32'h001FFFFD;
            5'd10:   v = 32'h000FFFFF;
            5'd11:   v = 32'h0007FFFF;
            5'd12:   v = 32'h0003FFFF;
            5'd13:   v = 32'h0001FFFF;
            5'd14:   v = 32'h0000FFFF;
            5'd15:   v = 32'h00007FFF;
            5'd16:   v = 32'h00003FFF;
            5'd17:   v = 32'h00001FFF;
            5'd18:   v = 32'h00000FFF;
            5'd19:   v = 32'h000007FF;
            5'd20:   v = 32'h000003FF;
            5'd21:   v = 32'h000001FF;
            5'd22:   v = 32'h000000FF;
            5'd23:   v = 32'h0000007F;
            5'd24:   v = 32'h0000003F;
            5'd25:   v = 32'h0000001F;
            5'd26:   v = 32'h0000000F;
            5'd27:   v = 32'h00000008;
            5'd28:   v = 32'h00000004;
            5'd29:   v = 32'h00000002;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    // Q.30 x Q.30 -> Q.30, round half up
    function automatic t_q30 mulq(input t_q30 a, input t_q30 b);
        logic signed [63:0] p;
        p = a * b;
        p = p + (64'sd1 <<< (FRAC_BITS - 1));
        return p[61:30];
    endfunction

    // 2*(p1+p2) from exact Q.60 products, round half up to Q.30
    function automatic t_mraw twice(input logic signed [63:0] p1,
                                    input logic signed [63:0] p2);
        logic signed [63:0] s;
        s = p1 + p2 + (64'sd1 <<< (FRAC_BITS - 2));
        return {s[63], s[63:29]};
    endfunction

    function automatic t_q30 clamp_unit(input t_mraw m);
        t_q30 v;
        if (m > 36'(ONE_Q30)) begin
            v = ONE_Q30;
        end else if (m < 36'(M_ONE_Q30)) begin
            v = M_ONE_Q30;
        end else begin
            v = m[31:0];
        end
        return v;
    endfunction

    // Q.46 accumulator -> Q16.16, round half up, saturate
    function automatic logic signed [31:0] sat_q16(input logic signed [63:0] acc);
        logic signed [63:0] r;
        logic signed [31:0] v;
        r = (acc + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (r > 64'sd2147483647) begin
            v = 32'sh7FFFFFFF;
        end else if (r < -64'sd2147483648) begin
            v = 32'sh80000000;
        end else begin
            v = r[31:0];
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// File: design/aavr_if.sv
// ----------------------------------------------------------------------------
// aavr_if
// Valid/ready channels for rotation requests and rotated vectors.
// ----------------------------------------------------------------------------
`default_nettype none

interface aavr_req_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic signed [31:0] axis_x;
    logic signed [31:0] axis_y;
    logic signed [31:0] axis_z;
    logic signed [31:0] angle_rad;

    modport source (output valid, vec_x, vec_y, vec_z, axis_x, axis_y, axis_z,
                    angle_rad, input ready);
    modport sink   (input valid, vec_x, vec_y, vec_z, axis_x, axis_y, axis_z,
                    angle_rad, output ready);
endinterface

interface aavr_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] rot_x;
    logic signed [31:0] rot_y;
    logic signed [31:0] rot_z;

    modport source (output valid, rot_x, rot_y, rot_z, input ready);
    modport sink   (input valid, rot_x, rot_y, rot_z, output ready);
endinterface

`default_nettype wire

// File: design/aavr_isqrt.sv
// ----------------------------------------------------------------------------
// aavr_isqrt
// Pipelined integer square root, one root bit per stage (floor result).
// ----------------------------------------------------------------------------
`default_nettype none

module aavr_isqrt (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [63:0] i_rad,
    output logic      [31:0] o_root
);
    import aavr_pkg::*;

    logic [35:0] r_rem  [0:SQRT_STEPS-1];
    logic [31:0] r_root [0:SQRT_STEPS-1];
    logic [63:0] r_rad  [0:SQRT_STEPS-1];

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
        logic [35:0] p_rem;
        logic [31:0] p_root;
        logic [63:0] p_rad;
        logic [35:0] w_sh;
        logic [35:0] w_trial;
        logic [35:0] n_rem;
        logic [31:0] n_root;

        if (k == 0) begin : g_first
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_rad  = i_rad;
        end else begin : g_next
            assign p_rem  = r_rem[k-1];
            assign p_root = r_root[k-1];
            assign p_rad  = r_rad[k-1];
        end

        always_comb begin
            w_sh    = {p_rem[33:0], p_rad[63:62]};
            w_trial = {2'b00, p_root, 2'b01};
            if (w_sh >= w_trial) begin
                n_rem  = w_sh - w_trial;
                n_root = {p_root[30:0], 1'b1};
            end else begin
                n_rem  = w_sh;
                n_root = {p_root[30:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_rad[k]  <= {p_rad[61:0], 2'b00};
            end
        end
    end

    assign o_root = r_root[SQRT_STEPS-1];

endmodule

`default_nettype wire

// File: design/aavr_udiv.sv
// ----------------------------------------------------------------------------
// aavr_udiv
// Pipelined restoring divider: one axis component over the axis length,
// rounded half up to Q2.30 and signed. Zero length gives zero.
// ----------------------------------------------------------------------------
`default_nettype none

module aavr_udiv (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic        [31:0] i_mag,
    input  wire logic               i_neg,
    input  wire logic        [31:0] i_len,
    output logic signed      [31:0] o_unit
);
    import aavr_pkg::*;

    logic [61:0] r_num;
    logic [31:0] r_den0;
    logic        r_neg0;
    logic        r_zero0;
    logic [61:0] n_num;

    assign n_num = {i_mag, 30'd0} + {31'd0, i_len[31:1]};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num   <= n_num;
            r_den0  <= i_len;
            r_neg0  <= i_neg;
            r_zero0 <= (i_len == '0);
        end
    end

    logic [31:0]          r_rem  [0:DIV_QBITS-1];
    logic [DIV_QBITS-1:0] r_quo  [0:DIV_QBITS-1];
    logic [DIV_QBITS-1:0] r_low  [0:DIV_QBITS-1];
    logic [31:0]          r_den  [0:DIV_QBITS-1];
    logic                 r_neg  [0:DIV_QBITS-1];
    logic                 r_zero [0:DIV_QBITS-1];

    for (genvar k = 0; k < DIV_QBITS; k++) begin : g_step
        logic [31:0]          p_rem;
        logic [DIV_QBITS-1:0] p_quo;
        logic [DIV_QBITS-1:0] p_low;
        logic [31:0]          p_den;
        logic                 p_neg;
        logic                 p_zero;
        logic [32:0]          w_sh;
        logic [31:0]          n_rem;
        logic                 n_bit;

        if (k == 0) begin : g_first
            // quotient fits in DIV_QBITS, so the top bits start as remainder
            assign p_rem  = {1'b0, r_num[61:DIV_QBITS]};
            assign p_quo  = '0;
            assign p_low  = r_num[DIV_QBITS-1:0];
            assign p_den  = r_den0;
            assign p_neg  = r_neg0;
            assign p_zero = r_zero0;
        end else begin : g_next
            assign p_rem  = r_rem[k-1];
            assign p_quo  = r_quo[k-1];
            assign p_low  = r_low[k-1];
            assign p_den  = r_den[k-1];
            assign p_neg  = r_neg[k-1];
            assign p_zero = r_zero[k-1];
        end

        always_comb begin
            w_sh = {p_rem, p_low[DIV_QBITS-1]};
            if (w_sh >= {1'b0, p_den}) begin
                n_rem = 32'(w_sh - {1'b0, p_den});
                n_bit = 1'b1;
            end else begin
                n_rem = w_sh[31:0];
                n_bit = 1'b0;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_quo[k]  <= {p_quo[DIV_QBITS-2:0], n_bit};
                r_low[k]  <= {p_low[DIV_QBITS-2:0], 1'b0};
                r_den[k]  <= p_den;
                r_neg[k]  <= p_neg;
                r_zero[k] <= p_zero;
            end
        end
    end

    logic signed [31:0] r_unit;
    logic signed [31:0] n_unit;
    logic        [31:0] w_q;

    assign w_q = {1'b0, r_quo[DIV_QBITS-1]};

    always_comb begin
        if (r_zero[DIV_QBITS-1]) begin
            n_unit = '0;
        end else if (r_neg[DIV_QBITS-1]) begin
            n_unit = -$signed(w_q);
        end else begin
            n_unit = $signed(w_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_unit <= n_unit;
        end
    end

    assign o_unit = r_unit;

endmodule

`default_nettype wire

// File: design/aavr_cordic.sv
// ----------------------------------------------------------------------------
// aavr_cordic
// Pipelined rotation-mode CORDIC: cos and sin of the half angle -angle/2,
// with quadrant folding by +-pi. Q.30 results.
// ----------------------------------------------------------------------------
`default_nettype none

module aavr_cordic (
    input  wire logic signed [31:0] i_angle,
    input  wire logic               i_clk,
    input  wire logic               i_en,
    output logic signed      [31:0] o_cos,
    output logic signed      [31:0] o_sin
);
    import aavr_pkg::*;

    logic signed [33:0] r_t0;
    logic               r_neg0;
    logic signed [33:0] w_ext;
    logic signed [33:0] w_t;
    logic signed [33:0] n_t0;
    logic               n_neg0;

    // Q4.28 angle -> Q.30 half angle: t = -2 * angle
    assign w_ext = {{2{i_angle[31]}}, i_angle};
    assign w_t   = 34'sd0 - (w_ext <<< 1);

    always_comb begin
        if (w_t > HALF_PI_Q30) begin
            n_t0   = w_t - PI_Q30;
            n_neg0 = 1'b1;
        end else if (w_t < -HALF_PI_Q30) begin
            n_t0   = w_t + PI_Q30;
            n_neg0 = 1'b1;
        end else begin
            n_t0   = w_t;
            n_neg0 = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t0   <= n_t0;
            r_neg0 <= n_neg0;
        end
    end

    logic signed [33:0] r_x   [0:CORDIC_ITERS-1];
    logic signed [33:0] r_y   [0:CORDIC_ITERS-1];
    logic signed [33:0] r_t   [0:CORDIC_ITERS-1];
    logic               r_neg [0:CORDIC_ITERS-1];

    for (genvar k = 0; k < CORDIC_ITERS; k++) begin : g_iter
        logic signed [33:0] p_x;
        logic signed [33:0] p_y;
        logic signed [33:0] p_t;
        logic               p_neg;
        logic signed [33:0] w_at;
        logic signed [33:0] n_x;
        logic signed [33:0] n_y;
        logic signed [33:0] n_t;

        if (k == 0) begin : g_first
            assign p_x   = CORDIC_GAIN_Q30;
            assign p_y   = '0;
            assign p_t   = r_t0;
            assign p_neg = r_neg0;
        end else begin : g_next
            assign p_x   = r_x[k-1];
            assign p_y   = r_y[k-1];
            assign p_t   = r_t[k-1];
            assign p_neg = r_neg[k-1];
        end

        assign w_at = $signed({2'b00, atan_lut(5'(k))});

        always_comb begin
            if (!p_t[33]) begin
                n_x = p_x - (p_y >>> k);
                n_y = p_y + (p_x >>> k);
                n_t = p_t - w_at;
            end else begin
                n_x = p_x + (p_y >>> k);
                n_y = p_y - (p_x >>> k);
                n_t = p_t + w_at;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k]   <= n_x;
                r_y[k]   <= n_y;
                r_t[k]   <= n_t;
                r_neg[k] <= p_neg;
            end
        end
    end

    logic signed [31:0] r_cos;
    logic signed [31:0] r_sin;
    logic signed [33:0] w_xf;
    logic signed [33:0] w_yf;

    assign w_xf = r_neg[CORDIC_ITERS-1] ? -r_x[CORDIC_ITERS-1] : r_x[CORDIC_ITERS-1];
    assign w_yf = r_neg[CORDIC_ITERS-1] ? -r_y[CORDIC_ITERS-1] : r_y[CORDIC_ITERS-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos <= w_xf[31:0];
            r_sin <= w_yf[31:0];
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

`default_nettype wire

// File: design/aavr_rotmat.sv
// ----------------------------------------------------------------------------
// aavr_rotmat
// Quaternion to rotation matrix and matrix-vector product, 7 stages:
// q, squares/cross products, raw entries, clamp, v*M terms, sums, round.
// ----------------------------------------------------------------------------
`default_nettype none

module aavr_rotmat (
    input  wire logic                  i_clk,
    input  wire logic                  i_en,
    input  wire aavr_pkg::t_q30        i_ux,
    input  wire aavr_pkg::t_q30        i_uy,
    input  wire aavr_pkg::t_q30        i_uz,
    input  wire aavr_pkg::t_q30        i_w,
    input  wire aavr_pkg::t_q30        i_s,
    input  wire logic signed    [31:0] i_vx,
    input  wire logic signed    [31:0] i_vy,
    input  wire logic signed    [31:0] i_vz,
    output logic signed         [31:0] o_rx,
    output logic signed         [31:0] o_ry,
    output logic signed         [31:0] o_rz
);
    import aavr_pkg::*;

    // stage 1: quaternion vector part and w^2
    t_q30               r1_qx, r1_qy, r1_qz, r1_w, r1_w2;
    logic signed [31:0] r1_v [0:2];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_qx   <= mulq(i_ux, i_s);
            r1_qy   <= mulq(i_uy, i_s);
            r1_qz   <= mulq(i_uz, i_s);
            r1_w    <= i_w;
            r1_w2   <= mulq(i_w, i_w);
            r1_v[0] <= i_vx;
            r1_v[1] <= i_vy;
            r1_v[2] <= i_vz;
        end
    end

    // stage 2: squares and exact cross products
    t_q30               r2_w2, r2_x2, r2_y2, r2_z2;
    logic signed [63:0] r2_xy, r2_wz, r2_xz, r2_wy, r2_yz, r2_wx;
    logic signed [31:0] r2_v [0:2];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_w2 <= r1_w2;
            r2_x2 <= mulq(r1_qx, r1_qx);
            r2_y2 <= mulq(r1_qy, r1_qy);
            r2_z2 <= mulq(r1_qz, r1_qz);
            r2_xy <= r1_qx * r1_qy;
            r2_wz <= r1_w * r1_qz;
            r2_xz <= r1_qx * r1_qz;
            r2_wy <= r1_w * r1_qy;
            r2_yz <= r1_qy * r1_qz;
            r2_wx <= r1_w * r1_qx;
            r2_v  <= r1_v;
        end
    end

    // stage 3: unclamped matrix entries
    t_mraw              r3_m [0:2][0:2];
    logic signed [31:0] r3_v [0:2];
    t_mraw              w_w2, w_x2, w_y2, w_z2;

    assign w_w2 = 36'(r2_w2);
    assign w_x2 = 36'(r2_x2);
    assign w_y2 = 36'(r2_y2);
    assign w_z2 = 36'(r2_z2);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_m[0][0] <= w_w2 + w_x2 - w_y2 - w_z2;
            r3_m[0][1] <= twice(r2_xy, r2_wz);
            r3_m[0][2] <= twice(r2_xz, -r2_wy);
            r3_m[1][0] <= twice(r2_xy, -r2_wz);
            r3_m[1][1] <= w_w2 - w_x2 + w_y2 - w_z2;
            r3_m[1][2] <= twice(r2_yz, r2_wx);
            r3_m[2][0] <= twice(r2_xz, r2_wy);
            r3_m[2][1] <= twice(r2_yz, -r2_wx);
            r3_m[2][2] <= w_w2 - w_x2 - w_y2 + w_z2;
            r3_v       <= r2_v;
        end
    end

    // stage 4: clamp entries to [-1, 1]
    t_q30               r4_m [0:2][0:2];
    logic signed [31:0] r4_v [0:2];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r4_m[i][j] <= clamp_unit(r3_m[i][j]);
                end
            end
            r4_v <= r3_v;
        end
    end

    // stage 5: nine products, stage 6: row sums, stage 7: round and saturate
    logic signed [63:0] r5_p [0:2][0:2];
    logic signed [63:0] r6_acc [0:2];
    logic signed [31:0] r7_r [0:2];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r5_p[i][j] <= r4_v[j] * r4_m[i][j];
                end
                r6_acc[i] <= r5_p[i][0] + r5_p[i][1] + r5_p[i][2];
                r7_r[i]   <= sat_q16(r6_acc[i]);
            end
        end
    end

    assign o_rx = r7_r[0];
    assign o_ry = r7_r[1];
    assign o_rz = r7_r[2];

endmodule

`default_nettype wire

// File: design/axis_angle_vector_rotate_core.sv
// ----------------------------------------------------------------------------
// axis_angle_vector_rotate_core
// Rotates a Q16.16 vector about an arbitrary axis by a Q4.28 angle through
// the equivalent quaternion rotation matrix; saturated Q16.16 result.
//
//   port     dir  flow         payload
//   i_req    in   valid/ready  vec_x/y/z, axis_x/y/z, angle_rad
//   o_rsp    out  valid/ready  rot_x/y/z
//
// One request per cycle while the output is not stalled. The result waits on
// the axis path: |a|^2, one-bit-per-stage square root, bit-per-stage
// normalize divide, then the matrix and product pipeline. The CORDIC runs
// alongside the divide and is matched by a delay line. Reset clears only
// the valid chain and the in-flight count. A stalled output freezes the
// whole pipeline and deasserts i_req.ready; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module axis_angle_vector_rotate_core (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    aavr_req_if.sink    i_req,
    aavr_rsp_if.source  o_rsp
);
    import aavr_pkg::*;

    localparam int LAT      = 2 + SQRT_LAT + DIV_LAT + ROT_LAT;
    localparam int SIDE_LEN = SQRT_LAT + DIV_LAT;
    localparam int TAP_MAG  = SQRT_LAT - 1;
    localparam int TAP_ANG  = SQRT_LAT + DIV_LAT - CORDIC_LAT - 1;
    localparam int TAP_VEC  = SIDE_LEN - 1;
    localparam int CNT_W    = $clog2(LAT + 1);

    typedef struct packed {
        logic signed [2:0][31:0] vec;
        logic signed [31:0]      ang;
        logic        [2:0][31:0] mag;
        logic        [2:0]       neg;
    } t_side;

    logic w_en;
    logic w_acc;
    logic [LAT-1:0] r_vld;

    assign w_en        = !r_vld[LAT-1] || o_rsp.ready;
    assign w_acc       = i_req.valid && w_en;
    assign i_req.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_req.valid};
        end
    end

    // stage 1: magnitudes and squares
    logic signed [31:0] w_ax [0:2];
    logic        [31:0] n_mag [0:2];
    logic        [63:0] r1_sq [0:2];
    t_side              r1_side;
    t_side              n_side;

    assign w_ax[0] = i_req.axis_x;
    assign w_ax[1] = i_req.axis_y;
    assign w_ax[2] = i_req.axis_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_mag[i]        = w_ax[i][31] ? (~w_ax[i] + 32'd1) : w_ax[i];
            n_side.mag[i]   = n_mag[i];
            n_side.neg[i]   = w_ax[i][31];
        end
        n_side.vec[0] = i_req.vec_x;
        n_side.vec[1] = i_req.vec_y;
        n_side.vec[2] = i_req.vec_z;
        n_side.ang    = i_req.angle_rad;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r1_sq[i] <= n_mag[i] * n_mag[i];
            end
            r1_side <= n_side;
        end
    end

    // stage 2: sum of squares (at most 3 * 2^62)
    logic [63:0] r2_sum;
    t_side       r2_side;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_sum  <= r1_sq[0] + r1_sq[1] + r1_sq[2];
            r2_side <= r1_side;
        end
    end

    // side data delay line
    t_side r_side [0:SIDE_LEN-1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0] <= r2_side;
            for (int k = 1; k < SIDE_LEN; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    logic [31:0] w_len;

    aavr_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (r2_sum),
        .o_root (w_len)
    );

    t_q30 w_u [0:2];

    for (genvar i = 0; i < 3; i++) begin : g_norm
        aavr_udiv u_udiv (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_mag  (r_side[TAP_MAG].mag[i]),
            .i_neg  (r_side[TAP_MAG].neg[i]),
            .i_len  (w_len),
            .o_unit (w_u[i])
        );
    end

    t_q30 w_cos;
    t_q30 w_sin;

    aavr_cordic u_cordic (
        .i_angle (r_side[TAP_ANG].ang),
        .i_clk   (i_clk),
        .i_en    (w_en),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    aavr_rotmat u_rotmat (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_ux  (w_u[0]),
        .i_uy  (w_u[1]),
        .i_uz  (w_u[2]),
        .i_w   (w_cos),
        .i_s   (w_sin),
        .i_vx  (r_side[TAP_VEC].vec[0]),
        .i_vy  (r_side[TAP_VEC].vec[1]),
        .i_vz  (r_side[TAP_VEC].vec[2]),
        .o_rx  (o_rsp.rot_x),
        .o_ry  (o_rsp.rot_y),
        .o_rz  (o_rsp.rot_z)
    );

    assign o_rsp.valid = r_vld[LAT-1];

    // requests in flight
    logic [CNT_W-1:0] r_cnt;
    logic             w_done;

    assign w_done = o_rsp.valid && o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            case ({w_acc, w_done})
                2'b10:   r_cnt <= r_cnt + CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_vld) == r_cnt)
        else $error("valid chain does not match requests in flight");

    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("pipeline moved during output stall");

    a_no_accept_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.ready) |-> !i_req.ready)
        else $error("request taken while result blocked");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp.valid)
        else $error("result valid right after reset");

endmodule

`default_nettype wire
